// ===== hdl/oracc_pkg.sv =====
package oracc_pkg;

  // field widths fixed by the item format
  localparam int ANG_BITS  = 17;
  localparam int AXIS_BITS = 16;
  localparam int IDX_BITS  = 3;
  localparam int TRIG_BITS = 33;
  localparam int Z_BITS    = 34;

  // angle scaling: a full turn is 360 * 128
  localparam int TURN128 = 46080;
  // floor(2^38 / 90), phase = floor(r * 2^23 / 90) with one correction step
  localparam logic [31:0] PH_RECIP = 32'd3054198966;
  localparam int PH_SHIFT = 15;

  // cordic constants
  localparam int ATAN_LEN = 30;
  localparam logic signed [TRIG_BITS-1:0] CORDIC_GAIN = 33'sd652032874;

  // configuration register indexes
  localparam logic [IDX_BITS-1:0] REG_AXIS_ONE_X = 3'd0;
  localparam logic [IDX_BITS-1:0] REG_AXIS_ONE_Y = 3'd1;
  localparam logic [IDX_BITS-1:0] REG_AXIS_ONE_Z = 3'd2;
  localparam logic [IDX_BITS-1:0] REG_AXIS_TWO_X = 3'd3;
  localparam logic [IDX_BITS-1:0] REG_AXIS_TWO_Y = 3'd4;
  localparam logic [IDX_BITS-1:0] REG_AXIS_TWO_Z = 3'd5;

  // tag carried alongside a lane operation
  typedef struct packed {
    logic       vld;
    logic       mat;
    logic [1:0] row;
  } lane_tag_t;

  // arctangent of 2^-i, 2^32 per turn
  function automatic logic [29:0] atan_q32(input logic [4:0] i);
    logic [29:0] v;
    case (i)
      5'd0:  v = 30'd536870912;
      5'd1:  v = 30'd316933406;
      5'd2:  v = 30'd167458907;
      5'd3:  v = 30'd85004756;
      5'd4:  v = 30'd42667331;
      5'd5:  v = 30'd21354465;
      5'd6:  v = 30'd10679838;
      5'd7:  v = 30'd5340245;
      5'd8:  v = 30'd2670163;
      5'd9:  v = 30'd1335087;
      5'd10: v = 30'd667544;
      5'd11: v = 30'd333772;
      5'd12: v = 30'd166886;
      5'd13: v = 30'd83443;
      5'd14: v = 30'd41722;
      5'd15: v = 30'd20861;
      5'd16: v = 30'd10430;
      5'd17: v = 30'd5215;
      5'd18: v = 30'd2608;
      5'd19: v = 30'd1304;
      5'd20: v = 30'd652;
      5'd21: v = 30'd326;
      5'd22: v = 30'd163;
      5'd23: v = 30'd81;
      5'd24: v = 30'd41;
      5'd25: v = 30'd20;
      5'd26: v = 30'd10;
      5'd27: v = 30'd5;
      5'd28: v = 30'd3;
      5'd29: v = 30'd1;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

endpackage

// ===== hdl/oracc_trig.sv =====
module oracc_trig import oracc_pkg::*; #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic signed [ANG_BITS-1:0]  angle,
  output logic                        done,
  output logic signed [TRIG_BITS-1:0] cos_v,
  output logic signed [TRIG_BITS-1:0] sin_v
);

  localparam int NSTEP = (CORDIC_STEPS < ATAN_LEN) ? CORDIC_STEPS : ATAN_LEN;
  localparam int IW = (NSTEP > 1) ? $clog2(NSTEP) : 1;
  localparam logic [IW-1:0] LAST = IW'(NSTEP - 1);

  typedef enum logic [2:0] {T_IDLE, T_RED, T_MUL, T_FOLD, T_ROT, T_DONE} tstate_t;

  tstate_t                     st_r;
  logic signed [ANG_BITS-1:0]  ang_r;
  logic [15:0]                 r_r;
  logic [47:0]                 prod_r;
  logic signed [TRIG_BITS-1:0] x_r, y_r, cos_r, sin_r;
  logic signed [Z_BITS-1:0]    z_r;
  logic                        neg_r, done_r;
  logic [IW-1:0]               it_r;

  logic signed [17:0]          ang18, red_v;
  logic [47:0]                 prod_nxt;
  logic [31:0]                 est, ph;
  logic [39:0]                 num, est90, rem;
  logic signed [31:0]          zs;
  logic signed [Z_BITS-1:0]    z_fold, atan_v;
  logic                        neg_fold;
  logic signed [TRIG_BITS-1:0] sh_x, sh_y;

  // reduce the angle into one turn
  always_comb begin
    ang18 = 18'(ang_r);
    if (ang18 >= 18'sd46080) begin
      red_v = ang18 - 18'sd46080;
    end else if (ang18 >= 18'sd0) begin
      red_v = ang18;
    end else if (ang18 >= -18'sd46080) begin
      red_v = ang18 + 18'sd46080;
    end else begin
      red_v = ang18 + 18'sd92160;
    end
  end

  assign prod_nxt = 48'(r_r) * 48'(PH_RECIP);

  // phase estimate, one correction step, then fold into half a turn
  always_comb begin
    est   = prod_r[PH_SHIFT+31:PH_SHIFT];
    num   = {1'b0, r_r, 23'd0};
    est90 = {2'b0, est, 6'd0} + {4'b0, est, 4'd0} + {5'b0, est, 3'd0} + {7'b0, est, 1'b0};
    rem   = num - est90;
    ph    = (rem >= 40'd90) ? est + 32'd1 : est;
    zs    = signed'(ph);
    if (zs > 32'sh4000_0000) begin
      z_fold   = Z_BITS'(zs) - 34'sh0_8000_0000;
      neg_fold = 1'b1;
    end else if (zs < -32'sh4000_0000) begin
      z_fold   = Z_BITS'(zs) + 34'sh0_8000_0000;
      neg_fold = 1'b1;
    end else begin
      z_fold   = Z_BITS'(zs);
      neg_fold = 1'b0;
    end
  end

  // cordic micro-rotation terms
  assign sh_x   = x_r >>> it_r;
  assign sh_y   = y_r >>> it_r;
  assign atan_v = signed'(Z_BITS'(atan_q32(5'(it_r))));

  // sequencer and datapath registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= T_IDLE;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      case (st_r)
        T_IDLE: begin
          if (start) begin
            ang_r <= angle;
            st_r  <= T_RED;
          end
        end
        T_RED: begin
          r_r  <= red_v[15:0];
          st_r <= T_MUL;
        end
        T_MUL: begin
          prod_r <= prod_nxt;
          st_r   <= T_FOLD;
        end
        T_FOLD: begin
          z_r   <= z_fold;
          neg_r <= neg_fold;
          x_r   <= CORDIC_GAIN;
          y_r   <= '0;
          it_r  <= '0;
          st_r  <= T_ROT;
        end
        T_ROT: begin
          if (!z_r[Z_BITS-1]) begin
            x_r <= x_r - sh_y;
            y_r <= y_r + sh_x;
            z_r <= z_r - atan_v;
          end else begin
            x_r <= x_r + sh_y;
            y_r <= y_r - sh_x;
            z_r <= z_r + atan_v;
          end
          if (it_r == LAST) begin
            st_r <= T_DONE;
          end else begin
            it_r <= it_r + 1'b1;
          end
        end
        T_DONE: begin
          cos_r  <= neg_r ? -x_r : x_r;
          sin_r  <= neg_r ? -y_r : y_r;
          done_r <= 1'b1;
          st_r   <= T_IDLE;
        end
        default: st_r <= T_IDLE;
      endcase
    end
  end

  assign done  = done_r;
  assign cos_v = cos_r;
  assign sin_v = sin_r;

endmodule

// ===== hdl/oracc_rod_lane.sv =====
module oracc_rod_lane import oracc_pkg::*; #(
  parameter int ELEMENT_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  lane_tag_t                      req,
  input  logic [1:0]                     col,
  input  logic signed [AXIS_BITS-1:0]    ax_x,
  input  logic signed [AXIS_BITS-1:0]    ax_y,
  input  logic signed [AXIS_BITS-1:0]    ax_z,
  input  logic signed [TRIG_BITS-1:0]    cos_v,
  input  logic signed [TRIG_BITS-1:0]    sin_v,
  output lane_tag_t                      rsp,
  output logic signed [ELEMENT_BITS-1:0] elem
);

  localparam logic signed [67:0] ELEM_HI = (68'sd1 <<< (ELEMENT_BITS - 1)) - 68'sd1;
  localparam logic signed [67:0] ELEM_LO = -(68'sd1 <<< (ELEMENT_BITS - 1));

  lane_tag_t                      tag1_r, tag2_r, tag3_r;
  logic                           diag1_r, negs1_r;
  logic signed [31:0]             p1_r;
  logic signed [48:0]             s1_r;
  logic signed [TRIG_BITS-1:0]    c1_r;
  logic signed [65:0]             prod2_r;
  logic signed [67:0]             add2_r;
  logic signed [ELEMENT_BITS-1:0] el_r;

  logic [2:0]                     sum_rc;
  logic [1:0]                     w_idx;
  logic                           diag, neg_s;
  logic signed [AXIS_BITS-1:0]    u, v, w;
  logic signed [31:0]             a_op;
  logic signed [33:0]             b_op;
  logic signed [67:0]             t, q;

  function automatic logic signed [AXIS_BITS-1:0] pick(
    input logic [1:0] k,
    input logic signed [AXIS_BITS-1:0] px,
    input logic signed [AXIS_BITS-1:0] py,
    input logic signed [AXIS_BITS-1:0] pz
  );
    logic signed [AXIS_BITS-1:0] r;
    case (k)
      2'd0:    r = px;
      2'd1:    r = py;
      default: r = pz;
    endcase
    return r;
  endfunction

  // element role from its row and column
  always_comb begin
    diag   = (req.row == col);
    sum_rc = 3'(req.row) + 3'(col);
    case (sum_rc)
      3'd1:    w_idx = 2'd2;
      3'd2:    w_idx = 2'd1;
      default: w_idx = 2'd0;
    endcase
    neg_s = (req.row == 2'd0 && col == 2'd1) || (req.row == 2'd1 && col == 2'd2) ||
            (req.row == 2'd2 && col == 2'd0);
    u = pick(req.row, ax_x, ax_y, ax_z);
    v = pick(col, ax_x, ax_y, ax_z);
    w = pick(w_idx, ax_x, ax_y, ax_z);
  end

  // second stage operands
  always_comb begin
    a_op = diag1_r ? (32'sd268435456 - p1_r) : p1_r;
    b_op = diag1_r ? 34'(c1_r) : (34'sd1073741824 - 34'(c1_r));
  end

  // round Q58 to Q14 and saturate
  always_comb begin
    t = 68'(prod2_r) + add2_r + 68'sd8796093022208;
    q = t >>> 44;
  end

  // stage registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag1_r <= '0;
      tag2_r <= '0;
      tag3_r <= '0;
    end else begin
      tag1_r <= req;
      tag2_r <= tag1_r;
      tag3_r <= tag2_r;
    end
  end

  always_ff @(posedge clk) begin
    diag1_r <= diag;
    negs1_r <= neg_s;
    p1_r    <= u * v;
    s1_r    <= w * sin_v;
    c1_r    <= cos_v;
    prod2_r <= a_op * b_op;
    if (diag1_r) begin
      add2_r <= 68'(p1_r) <<< 30;
    end else if (negs1_r) begin
      add2_r <= -(68'(s1_r) <<< 14);
    end else begin
      add2_r <= 68'(s1_r) <<< 14;
    end
    if (q > ELEM_HI) begin
      el_r <= ELEM_HI[ELEMENT_BITS-1:0];
    end else if (q < ELEM_LO) begin
      el_r <= ELEM_LO[ELEMENT_BITS-1:0];
    end else begin
      el_r <= q[ELEMENT_BITS-1:0];
    end
  end

  assign rsp  = tag3_r;
  assign elem = el_r;

endmodule

// ===== hdl/oracc_mac_lane.sv =====
module oracc_mac_lane import oracc_pkg::*; #(
  parameter int ELEMENT_BITS = 16,
  parameter int IN_BITS      = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  lane_tag_t                      req,
  input  logic signed [IN_BITS-1:0]      a_row [3],
  input  logic signed [IN_BITS-1:0]      b_col [3],
  output lane_tag_t                      rsp,
  output logic signed [ELEMENT_BITS-1:0] elem
);

  localparam int PW = 2 * IN_BITS;
  localparam int SW = PW + 2;
  localparam int CW = (SW > 62) ? SW : 62;
  localparam logic signed [CW-1:0] LIM = CW'(64'sd1 <<< 60);
  localparam logic signed [CW:0] RND = (CW+1)'(64'sd8192);
  localparam logic signed [CW:0] ELEM_HI = ((CW+1)'(64'sd1) <<< (ELEMENT_BITS - 1)) - 1;
  localparam logic signed [CW:0] ELEM_LO = -((CW+1)'(64'sd1) <<< (ELEMENT_BITS - 1));

  lane_tag_t                      tag1_r, tag2_r;
  logic signed [PW-1:0]           p_r [3];
  logic signed [ELEMENT_BITS-1:0] el_r;

  logic signed [CW-1:0]           acc, accc;
  logic signed [CW:0]             q;

  // sum of products, clamp, round and saturate
  always_comb begin
    acc = CW'(p_r[0]) + CW'(p_r[1]) + CW'(p_r[2]);
    if (acc > LIM) begin
      accc = LIM;
    end else if (acc < -LIM) begin
      accc = -LIM;
    end else begin
      accc = acc;
    end
    q = ((CW+1)'(accc) + RND) >>> 14;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag1_r <= '0;
      tag2_r <= '0;
    end else begin
      tag1_r <= req;
      tag2_r <= tag1_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      p_r[k] <= a_row[k] * b_col[k];
    end
    if (q > ELEM_HI) begin
      el_r <= ELEM_HI[ELEMENT_BITS-1:0];
    end else if (q < ELEM_LO) begin
      el_r <= ELEM_LO[ELEMENT_BITS-1:0];
    end else begin
      el_r <= q[ELEMENT_BITS-1:0];
    end
  end

  assign rsp  = tag2_r;
  assign elem = el_r;

endmodule

// ===== hdl/orientation_rotation_accumulator_top.sv =====
// one item at a time: in_tready is high only in the idle state, after the last result is
// loaded into the output register; the cordic iteration (one step per cycle) and the
// three-lane rodrigues and matrix product passes make up the work on each item
// a finished result waits in the output register while the next item is worked on
// reset (synchronous, active low): orientation to identity, axes to x and y,
// handshakes idle
module orientation_rotation_accumulator_top import oracc_pkg::*; #(
  parameter int ELEMENT_BITS = 16,
  parameter int CORDIC_STEPS = 16
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      in_tvalid,
  output logic                                      in_tready,
  // angle_one [16:0], angle_two [33:17], zero fill
  input  logic [39:0]                               in_tdata,
  output logic                                      out_tvalid,
  input  logic                                      out_tready,
  // row0_col0, row0_col1, .. row2_col2, ELEMENT_BITS each, zero fill
  output logic [((9*ELEMENT_BITS+7)/8)*8-1:0]       out_tdata,
  input  logic                                      cfg_we,
  input  logic [IDX_BITS-1:0]                       cfg_idx,
  input  logic [AXIS_BITS-1:0]                      cfg_wdata
);

  localparam int EB    = ELEMENT_BITS;
  localparam int OW    = (EB > 16) ? EB : 16;
  localparam int OUT_W = ((9*EB+7)/8)*8;

  typedef enum logic [3:0] {
    S_IDLE, S_TRIG, S_ROD, S_ROD_W, S_MUL1, S_MUL1_W, S_MUL2, S_MUL2_W, S_COMMIT, S_OUT
  } state_t;

  state_t                      state_r;
  logic [1:0]                  row_r;
  logic                        mat_r;
  logic                        out_vld_r;
  logic [OUT_W-1:0]            out_dat_r;

  logic signed [AXIS_BITS-1:0] ax1_r [3];
  logic signed [AXIS_BITS-1:0] ax2_r [3];
  logic signed [EB-1:0]        m1_r [3][3];
  logic signed [EB-1:0]        m2_r [3][3];
  logic signed [EB-1:0]        mr_r [3][3];
  logic signed [EB-1:0]        nf_r [3][3];
  logic signed [OW-1:0]        ori_r [3][3];

  logic                        tr_start;
  logic [1:0]                  tr_done;
  logic signed [TRIG_BITS-1:0] tr_cos [2];
  logic signed [TRIG_BITS-1:0] tr_sin [2];

  lane_tag_t                   rod_req, mac_req;
  lane_tag_t                   rod_rsp [3];
  lane_tag_t                   mac_rsp [3];
  logic signed [EB-1:0]        rod_el [3];
  logic signed [EB-1:0]        mac_el [3];
  logic signed [AXIS_BITS-1:0] rx, ry, rz;
  logic signed [TRIG_BITS-1:0] rc, rs;
  logic signed [OW-1:0]        a_row [3];
  logic signed [OW-1:0]        b_col [3][3];
  logic [OUT_W-1:0]            out_pack;

  assign in_tready = (state_r == S_IDLE);
  assign tr_start  = in_tvalid && in_tready;

  // two trig lanes, one per angle
  oracc_trig #(.CORDIC_STEPS(CORDIC_STEPS)) u_trig_one (
    .clk(clk), .rst_n(rst_n), .start(tr_start), .angle(signed'(in_tdata[16:0])),
    .done(tr_done[0]), .cos_v(tr_cos[0]), .sin_v(tr_sin[0])
  );
  oracc_trig #(.CORDIC_STEPS(CORDIC_STEPS)) u_trig_two (
    .clk(clk), .rst_n(rst_n), .start(tr_start), .angle(signed'(in_tdata[33:17])),
    .done(tr_done[1]), .cos_v(tr_cos[1]), .sin_v(tr_sin[1])
  );

  // operands for the rodrigues lanes
  always_comb begin
    rod_req = '{vld: (state_r == S_ROD), mat: mat_r, row: row_r};
    rx = mat_r ? ax2_r[0] : ax1_r[0];
    ry = mat_r ? ax2_r[1] : ax1_r[1];
    rz = mat_r ? ax2_r[2] : ax1_r[2];
    rc = mat_r ? tr_cos[1] : tr_cos[0];
    rs = mat_r ? tr_sin[1] : tr_sin[0];
  end

  // operands for the product lanes: row 0 of a rotating matrix, fixed columns
  always_comb begin
    mac_req = '{vld: (state_r == S_MUL1 || state_r == S_MUL2), mat: (state_r == S_MUL2),
                row: row_r};
    for (int k = 0; k < 3; k++) begin
      a_row[k] = (state_r == S_MUL2) ? OW'(mr_r[0][k]) : OW'(m1_r[0][k]);
      for (int j = 0; j < 3; j++) begin
        b_col[j][k] = (state_r == S_MUL2) ? ori_r[k][j] : OW'(m2_r[k][j]);
      end
    end
  end

  for (genvar j = 0; j < 3; j++) begin : g_lane
    oracc_rod_lane #(.ELEMENT_BITS(EB)) u_rod (
      .clk(clk), .rst_n(rst_n), .req(rod_req), .col(2'(j)),
      .ax_x(rx), .ax_y(ry), .ax_z(rz), .cos_v(rc), .sin_v(rs),
      .rsp(rod_rsp[j]), .elem(rod_el[j])
    );
    oracc_mac_lane #(.ELEMENT_BITS(EB), .IN_BITS(OW)) u_mac (
      .clk(clk), .rst_n(rst_n), .req(mac_req), .a_row(a_row), .b_col(b_col[j]),
      .rsp(mac_rsp[j]), .elem(mac_el[j])
    );
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ax1_r[0] <= 16'sd16384;
      ax1_r[1] <= '0;
      ax1_r[2] <= '0;
      ax2_r[0] <= '0;
      ax2_r[1] <= 16'sd16384;
      ax2_r[2] <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_AXIS_ONE_X: ax1_r[0] <= signed'(cfg_wdata);
        REG_AXIS_ONE_Y: ax1_r[1] <= signed'(cfg_wdata);
        REG_AXIS_ONE_Z: ax1_r[2] <= signed'(cfg_wdata);
        REG_AXIS_TWO_X: ax2_r[0] <= signed'(cfg_wdata);
        REG_AXIS_TWO_Y: ax2_r[1] <= signed'(cfg_wdata);
        REG_AXIS_TWO_Z: ax2_r[2] <= signed'(cfg_wdata);
        default: ;
      endcase
    end
  end

  // merge lane results into the working matrices
  always_ff @(posedge clk) begin
    if (state_r == S_MUL1) begin
      m1_r[0] <= m1_r[1];
      m1_r[1] <= m1_r[2];
      m1_r[2] <= m1_r[0];
    end else begin
      for (int j = 0; j < 3; j++) begin
        if (rod_rsp[j].vld && !rod_rsp[j].mat) begin
          m1_r[rod_rsp[j].row][j] <= rod_el[j];
        end
      end
    end
    for (int j = 0; j < 3; j++) begin
      if (rod_rsp[j].vld && rod_rsp[j].mat) begin
        m2_r[rod_rsp[j].row][j] <= rod_el[j];
      end
      if (mac_rsp[j].vld && mac_rsp[j].mat) begin
        nf_r[mac_rsp[j].row][j] <= mac_el[j];
      end
    end
    if (state_r == S_MUL2) begin
      mr_r[0] <= mr_r[1];
      mr_r[1] <= mr_r[2];
      mr_r[2] <= mr_r[0];
    end else begin
      for (int j = 0; j < 3; j++) begin
        if (mac_rsp[j].vld && !mac_rsp[j].mat) begin
          mr_r[mac_rsp[j].row][j] <= mac_el[j];
        end
      end
    end
  end

  // packed result from the orientation
  always_comb begin
    out_pack = '0;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        out_pack[(r*3+c)*EB +: EB] = ori_r[r][c][EB-1:0];
      end
    end
  end

  // sequencer, orientation state and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      row_r     <= '0;
      mat_r     <= 1'b0;
      out_vld_r <= 1'b0;
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          ori_r[r][c] <= (r == c) ? OW'(32'sd16384) : '0;
        end
      end
    end else begin
      if (out_vld_r && out_tready && state_r != S_OUT) begin
        out_vld_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            state_r <= S_TRIG;
          end
        end
        S_TRIG: begin
          if (tr_done[0]) begin
            row_r   <= '0;
            mat_r   <= 1'b0;
            state_r <= S_ROD;
          end
        end
        S_ROD: begin
          if (row_r == 2'd2) begin
            row_r <= '0;
            if (mat_r) begin
              state_r <= S_ROD_W;
            end else begin
              mat_r <= 1'b1;
            end
          end else begin
            row_r <= row_r + 2'd1;
          end
        end
        S_ROD_W: begin
          if (rod_rsp[0].vld && rod_rsp[0].mat && rod_rsp[0].row == 2'd2) begin
            row_r   <= '0;
            state_r <= S_MUL1;
          end
        end
        S_MUL1: begin
          if (row_r == 2'd2) begin
            state_r <= S_MUL1_W;
          end
          row_r <= (row_r == 2'd2) ? 2'd0 : row_r + 2'd1;
        end
        S_MUL1_W: begin
          if (mac_rsp[0].vld && mac_rsp[0].row == 2'd2) begin
            row_r   <= '0;
            state_r <= S_MUL2;
          end
        end
        S_MUL2: begin
          if (row_r == 2'd2) begin
            state_r <= S_MUL2_W;
          end
          row_r <= (row_r == 2'd2) ? 2'd0 : row_r + 2'd1;
        end
        S_MUL2_W: begin
          if (mac_rsp[0].vld && mac_rsp[0].row == 2'd2) begin
            state_r <= S_COMMIT;
          end
        end
        S_COMMIT: begin
          for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
              ori_r[r][c] <= OW'(nf_r[r][c]);
            end
          end
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (!out_vld_r || out_tready) begin
            out_dat_r <= out_pack;
            out_vld_r <= 1'b1;
            state_r   <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_dat_r;

  // no lane result may arrive while the block waits for an item
  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (!rod_rsp[0].vld && !mac_rsp[0].vld))
    else $error("lane result while idle");

  // both trig lanes run in lockstep
  a_trig_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
    tr_done[0] == tr_done[1])
    else $error("trig lanes out of step");

  // one item at a time
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("second item accepted while busy");

  // a new result is only loaded from the output state
  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(state_r == S_OUT))
    else $error("result loaded outside output state");

endmodule

// ===== sim/testbench.sv =====
module testbench;
  import oracc_pkg::*;

  localparam int EB = 16;
  localparam int OUT_W = ((9*EB+7)/8)*8;
  localparam int STEPS = 16;
  localparam int WATCHDOG_LIMIT = 4000;
  // indexes past the last axis register, writes there must be dropped
  localparam logic [IDX_BITS-1:0] REG_SPARE_A = 3'd6;
  localparam logic [IDX_BITS-1:0] REG_SPARE_B = 3'd7;

  // tracks the orientation matrix and queues the expected matrices
  class orientation_tracker;
    longint axis [6];
    longint orient [9];
    logic [9*EB-1:0] expected_q [$];
    int errors;
    int matrices;
    longint atan_t [16] = '{536870912, 316933406, 167458907, 85004756, 42667331,
                            21354465, 10679838, 5340245, 2670163, 1335087, 667544,
                            333772, 166886, 83443, 41722, 20861};

    function new();
      axis = '{16384, 0, 0, 0, 16384, 0};
      foreach (orient[i]) orient[i] = (i % 4 == 0) ? 16384 : 0;
      errors = 0;
      matrices = 0;
    endfunction

    function void set_reg(logic [IDX_BITS-1:0] idx, logic signed [AXIS_BITS-1:0] v);
      case (idx)
        REG_AXIS_ONE_X: axis[0] = v;
        REG_AXIS_ONE_Y: axis[1] = v;
        REG_AXIS_ONE_Z: axis[2] = v;
        REG_AXIS_TWO_X: axis[3] = v;
        REG_AXIS_TWO_Y: axis[4] = v;
        REG_AXIS_TWO_Z: axis[5] = v;
        default: ;
      endcase
    endfunction

    function longint clamp_elem(longint v);
      longint hi;
      hi = (longint'(1) <<< (EB-1)) - 1;
      return v > hi ? hi : (v < -hi-1 ? -hi-1 : v);
    endfunction

    // degrees*128 to cos/sin in Q30
    function void sine_cosine(longint a, output longint c, output longint s);
      longint r, z, x, y, t;
      bit flip;
      r = a % TURN128;
      if (r < 0) r += TURN128;
      z = (r <<< 32) / TURN128;
      if (z >= (longint'(1) <<< 31)) z -= longint'(1) <<< 32;
      flip = 0;
      // fold into the right half plane
      if (z > (longint'(1) <<< 30)) begin
        z -= longint'(1) <<< 31;
        flip = 1;
      end else if (z < -(longint'(1) <<< 30)) begin
        z += longint'(1) <<< 31;
        flip = 1;
      end
      x = 652032874;
      y = 0;
      for (int i = 0; i < STEPS; i++) begin
        if (z >= 0) begin
          t = x - (y >>> i);
          y = y + (x >>> i);
          z -= atan_t[i];
        end else begin
          t = x + (y >>> i);
          y = y - (x >>> i);
          z += atan_t[i];
        end
        x = t;
      end
      c = flip ? -x : x;
      s = flip ? -y : y;
    endfunction

    function longint round_q58(longint v);
      return clamp_elem((v + (longint'(1) <<< 43)) >>> 44);
    endfunction

    function void axis_rotation(longint x, longint y, longint z, longint ang,
                                output longint m [9]);
      longint c, s, omc, k30, k14, one28;
      k30 = longint'(1) <<< 30;
      k14 = longint'(1) <<< 14;
      one28 = longint'(1) <<< 28;
      sine_cosine(ang, c, s);
      omc = k30 - c;
      m[0] = round_q58(x*x*k30 + (one28 - x*x)*c);
      m[4] = round_q58(y*y*k30 + (one28 - y*y)*c);
      m[8] = round_q58(z*z*k30 + (one28 - z*z)*c);
      m[1] = round_q58(x*y*omc - z*s*k14);
      m[3] = round_q58(x*y*omc + z*s*k14);
      m[2] = round_q58(x*z*omc + y*s*k14);
      m[6] = round_q58(x*z*omc - y*s*k14);
      m[5] = round_q58(y*z*omc - x*s*k14);
      m[7] = round_q58(y*z*omc + x*s*k14);
    endfunction

    function void mat_product(longint a [9], longint b [9], output longint r [9]);
      longint acc, lim;
      lim = longint'(1) <<< 60;
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++) begin
          acc = a[i*3]*b[j] + a[i*3+1]*b[3+j] + a[i*3+2]*b[6+j];
          if (acc > lim) acc = lim;
          if (acc < -lim) acc = -lim;
          r[i*3+j] = clamp_elem((acc + (longint'(1) <<< 13)) >>> 14);
        end
    endfunction

    function void note_angles(logic signed [ANG_BITS-1:0] a1, logic signed [ANG_BITS-1:0] a2);
      longint m1 [9], m2 [9], mr [9], nf [9];
      logic [9*EB-1:0] packed_m;
      axis_rotation(axis[0], axis[1], axis[2], a1, m1);
      axis_rotation(axis[3], axis[4], axis[5], a2, m2);
      mat_product(m1, m2, mr);
      mat_product(mr, orient, nf);
      foreach (nf[i]) begin
        orient[i] = nf[i];
        packed_m[i*EB +: EB] = nf[i][EB-1:0];
      end
      expected_q.push_back(packed_m);
    endfunction

    function void check_matrix(logic [OUT_W-1:0] got);
      logic [9*EB-1:0] want;
      string names [9] = '{"row0_col0", "row0_col1", "row0_col2", "row1_col0",
                           "row1_col1", "row1_col2", "row2_col0", "row2_col1",
                           "row2_col2"};
      matrices++;
      if (expected_q.size() == 0) begin
        $error("result with nothing expected: %h", got);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      for (int i = 0; i < 9; i++)
        if (got[i*EB +: EB] !== want[i*EB +: EB]) begin
          $error("%s: expected %0d, got %0d", names[i],
                 $signed(want[i*EB +: EB]), $signed(got[i*EB +: EB]));
          errors++;
        end
    endfunction
  endclass

  logic clk, rst_n;
  logic in_tvalid, in_tready, out_tvalid, out_tready, cfg_we;
  logic [39:0] in_tdata;
  logic [OUT_W-1:0] out_tdata;
  logic [IDX_BITS-1:0] cfg_idx;
  logic [AXIS_BITS-1:0] cfg_wdata;

  orientation_tracker tracker;
  bit gaps_on;
  int quiet_cycles;
  int items_sent;

  orientation_rotation_accumulator_top #(.ELEMENT_BITS(EB), .CORDIC_STEPS(STEPS)) u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  function int draw_gap();
    return gaps_on ? $urandom_range(0, 11) : 0;
  endfunction

  task automatic send_angles(logic signed [ANG_BITS-1:0] a1, logic signed [ANG_BITS-1:0] a2);
    int gap;
    gap = draw_gap();
    repeat (gap) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata <= {6'd0, a2, a1};
    do @(posedge clk); while (!in_tready);
    tracker.note_angles(a1, a2);
    items_sent++;
  endtask

  task automatic write_reg(logic [IDX_BITS-1:0] idx, logic signed [AXIS_BITS-1:0] v);
    @(negedge clk);
    in_tvalid <= 1'b0;
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    tracker.set_reg(idx, v);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // let every queued matrix come back before touching the axes
  task automatic drain();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (tracker.expected_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  task automatic set_axes(longint v [6]);
    drain();
    write_reg(REG_AXIS_ONE_X, AXIS_BITS'(v[0]));
    write_reg(REG_AXIS_ONE_Y, AXIS_BITS'(v[1]));
    write_reg(REG_AXIS_ONE_Z, AXIS_BITS'(v[2]));
    write_reg(REG_AXIS_TWO_X, AXIS_BITS'(v[3]));
    write_reg(REG_AXIS_TWO_Y, AXIS_BITS'(v[4]));
    write_reg(REG_AXIS_TWO_Z, AXIS_BITS'(v[5]));
    // stray indexes must leave the axes alone
    write_reg(REG_SPARE_A, AXIS_BITS'($urandom));
    write_reg(REG_SPARE_B, AXIS_BITS'($urandom));
  endtask

  function logic signed [ANG_BITS-1:0] draw_angle();
    if ($urandom_range(0, 4) == 0) return ANG_BITS'($urandom);
    return ANG_BITS'($urandom_range(0, 2*TURN128) - TURN128);
  endfunction

  // result side
  initial begin
    int gap;
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      gap = draw_gap();
      repeat (gap) begin
        @(negedge clk);
        out_tready <= 1'b0;
      end
      @(negedge clk);
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      tracker.check_matrix(out_tdata);
    end
  end

  // watchdog on handshake progress
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we || !rst_n)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // stimulus
  initial begin
    longint axes [6];
    longint units [6][3] = '{'{16384, 0, 0}, '{0, -16384, 0}, '{0, 0, 16384},
                             '{9459, 9459, 9459}, '{11585, -11585, 0},
                             '{0, 11585, -11585}};
    int u1, u2, kind;
    tracker = new();
    items_sent = 0;
    gaps_on = 1;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_wdata = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: zero, quarter turns, fold edges, full turns, raw 17-bit extremes
    send_angles(0, 0);
    send_angles(11520, 0);
    send_angles(0, 11520);
    send_angles(23040, -23040);
    send_angles(11519, 11521);
    send_angles(-11519, -11521);
    send_angles(34560, -34560);
    send_angles(34559, 34561);
    send_angles(46080, -46080);
    send_angles(-65536, 65535);
    send_angles(65535, -65536);
    send_angles(1, -1);
    send_angles(23039, 23041);
    // non-unit extreme axes drive the elements into saturation
    axes = '{16384, 16384, 16384, -16384, -16384, -16384};
    set_axes(axes);
    send_angles(5760, 5760);
    send_angles(-17280, 40000);
    send_angles(17280, 0);
    axes = '{-16384, 0, 0, 0, 0, 16384};
    set_axes(axes);
    send_angles(11520, -11520);
    send_angles(0, 23040);

    // random phases with differing axis settings
    for (int ph = 0; ph < 12; ph++) begin
      kind = ph % 3;
      u1 = $urandom_range(0, 5);
      u2 = $urandom_range(0, 5);
      for (int k = 0; k < 3; k++) begin
        if (kind == 2) begin
          axes[k] = $urandom_range(0, 32768) - 16384;
          axes[3+k] = $urandom_range(0, 32768) - 16384;
        end else begin
          axes[k] = units[u1][k];
          axes[3+k] = units[u2][k];
        end
      end
      set_axes(axes);
      gaps_on = (ph % 4 != 1);
      repeat (105) send_angles(draw_angle(), draw_angle());
    end
    gaps_on = 1;

    drain();
    $display("run: %0d items sent, %0d matrices checked over directed and random axes",
             items_sent, tracker.matrices);
    if (tracker.errors == 0 && tracker.expected_q.size() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end
endmodule

// ===== orientation_rotation_accumulator_top.f =====
hdl/oracc_pkg.sv
hdl/oracc_trig.sv
hdl/oracc_rod_lane.sv
hdl/oracc_mac_lane.sv
hdl/orientation_rotation_accumulator_top.sv
sim/testbench.sv
